FILE: rtl/hpr_pkg.sv
// Package for the hazard pointer reclaimer: sizes, action and result codes,
// controller command and status structs. No dependencies.
`timescale 1ns / 1ps
package hpr_pkg;
	localparam int SLOTS      = 64;
	localparam int SLOT_W     = 6;
	localparam int HP_W       = 7;
	localparam int DEPTH      = 32;
	localparam int DIDX_W     = 5;
	localparam int CNT_W      = 6;
	localparam int PTR_W      = 64;
	localparam int TAG_W      = 8;
	localparam int RETRIES    = 2;

	typedef enum logic [2:0] {
		ACT_ATTACH = 3'd0,
		ACT_DETACH = 3'd1,
		ACT_SET    = 3'd2,
		ACT_RETIRE = 3'd3,
		ACT_FLUSH  = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		K_RELEASE   = 3'd0,
		K_QUEUED    = 3'd1,
		K_FULL      = 3'd2,
		K_ASSIGNED  = 3'd3,
		K_NOSLOT    = 3'd4,
		K_DONE      = 3'd5,
		K_BADDETACH = 3'd6
	} kind_t;

	// controller -> datapath
	typedef struct packed {
		logic       load;      // capture input transaction
		logic       scan_init; // start hazard scan (of candidate)
		logic       scan_step; // compare one slot
		logic       rd_entry;  // issue delayed-queue read at entry_idx
		logic       cand_new;  // candidate is the new pointer, else read data
		logic       free_step; // attach search step
		logic       attach_do; // commit attach
		logic       hp_clr;    // clear one hazard word of found slot (idx=clr_sel)
		logic       clr_sel;
		logic       detach_do;
		logic       set_do;
		logic       rel_entry; // release entry: move last into entry_idx
		logic       enqueue;
		logic       entry_ld;  // entry_idx <- entry_src
		logic [1:0] entry_src; // 0: retries, 1: count-1, 2: entry-1
		logic       out_ld;
		kind_t      out_kind;
		logic [1:0] out_src;   // 0 none, 1 candidate, 2 slot
		logic       out_last;
	} hpr_cmd_t;

	// datapath -> controller
	typedef struct packed {
		action_t    action;
		logic       scan_busy;
		logic       hazard;
		logic       search_busy;
		logic       found;
		logic       detach_ok;
		logic       entry_valid; // entry_idx < count
		logic       entry_zero;
		logic       q_full;
		logic       out_busy;
		logic       move_busy;
	} hpr_sts_t;
endpackage

FILE: rtl/hpr_ram.sv
// Generic single-port-write, one-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module hpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: rtl/hpr_datapath.sv
// Datapath: slot table, hazard RAM, delayed queue RAM, scan and output register.
// Depends on hpr_pkg and hpr_ram.
`timescale 1ns / 1ps
module hpr_datapath
	import hpr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  hpr_cmd_t             cmd,
	output hpr_sts_t             sts,
	input  logic [2:0]           action,
	input  logic [SLOT_W-1:0]    thread_slot,
	input  logic                 hazard_index,
	input  logic [PTR_W-1:0]     pointer_value,
	input  logic [TAG_W-1:0]     release_tag,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [2:0]           result_kind,
	output logic [PTR_W-1:0]     released_pointer,
	output logic [TAG_W-1:0]     released_tag,
	output logic [SLOT_W-1:0]    assigned_slot,
	output logic                 last_result
);
	logic [2:0]        act_q;
	logic [SLOT_W-1:0] slot_q;
	logic              hidx_q;
	logic [PTR_W-1:0]  ptr_q;
	logic [TAG_W-1:0]  tag_q;

	logic [SLOTS-1:0]  in_use_q;
	logic [SLOT_W:0]   hi_q;    // highest slot plus one
	logic [SLOT_W:0]   hint_q;
	logic [CNT_W-1:0]  cnt_q;

	// hazard RAM: one read port used by the scan, written by set/attach
	logic              hp_we;
	logic [HP_W-1:0]   hp_waddr, hp_raddr;
	logic [PTR_W-1:0]  hp_wdata, hp_rdata;
	// scan: address counter, registered RAM read
	logic [HP_W:0]     scan_addr_q;  // next word to read
	logic [HP_W:0]     scan_lim_q;
	logic              rd_pend_q;
	logic              scan_busy_q;
	logic              hit_q;
	logic [PTR_W-1:0]  cand_q;
	logic [TAG_W-1:0]  cand_tag_q;

	// delayed queue RAMs
	logic              dq_we;
	logic [DIDX_W-1:0] dq_waddr, dq_raddr;
	logic [PTR_W-1:0]  dqp_wdata, dqp_rdata;
	logic [TAG_W-1:0]  dqt_wdata, dqt_rdata;
	logic [CNT_W-1:0]  entry_q;
	logic [1:0]        move_q;  // release move sequence
	logic [DIDX_W-1:0] move_dst_q;

	// attach search
	logic [SLOT_W:0]   srch_q;
	logic              srch_wrap_q;
	logic              srch_busy_q;
	logic              found_q;
	logic [SLOT_W-1:0] found_slot_q;

	logic [SLOT_W:0]   srch_lim;
	assign srch_lim = srch_wrap_q ? hint_q : (SLOT_W+1)'(SLOTS);

	hpr_ram #(.WIDTH(PTR_W), .DEPTH(2*SLOTS)) u_hp (
		.clk, .we(hp_we), .waddr(hp_waddr), .wdata(hp_wdata),
		.raddr(hp_raddr), .rdata(hp_rdata)
	);
	hpr_ram #(.WIDTH(PTR_W), .DEPTH(DEPTH)) u_dqp (
		.clk, .we(dq_we), .waddr(dq_waddr), .wdata(dqp_wdata),
		.raddr(dq_raddr), .rdata(dqp_rdata)
	);
	hpr_ram #(.WIDTH(TAG_W), .DEPTH(DEPTH)) u_dqt (
		.clk, .we(dq_we), .waddr(dq_waddr), .wdata(dqt_wdata),
		.raddr(dq_raddr), .rdata(dqt_rdata)
	);

	assign hp_raddr = scan_addr_q[HP_W-1:0];

	always_comb begin
		hp_we    = 1'b0;
		hp_waddr = {slot_q, hidx_q};
		hp_wdata = ptr_q;
		if (cmd.set_do) begin
			hp_we = 1'b1;
		end
		if (cmd.hp_clr) begin
			hp_we    = 1'b1;
			hp_waddr = {found_slot_q, cmd.clr_sel};
			hp_wdata = '0;
		end
	end

	// delayed queue: reads at entry (or last during a move), writes on enqueue/move
	always_comb begin
		dq_raddr  = entry_q[DIDX_W-1:0];
		if (move_q != 2'd0) dq_raddr = DIDX_W'(cnt_q);
		dq_we     = 1'b0;
		dq_waddr  = DIDX_W'(cnt_q);
		dqp_wdata = ptr_q;
		dqt_wdata = tag_q;
		if (cmd.enqueue) dq_we = 1'b1;
		if (move_q == 2'd1) begin
			dq_we     = 1'b1;
			dq_waddr  = move_dst_q;
			dqp_wdata = dqp_rdata;
			dqt_wdata = dqt_rdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q  <= action;
			slot_q <= thread_slot;
			hidx_q <= hazard_index;
			ptr_q  <= pointer_value;
			tag_q  <= release_tag;
		end
		if (cmd.scan_init) begin
			cand_q     <= cmd.cand_new ? ptr_q : dqp_rdata;
			cand_tag_q <= cmd.cand_new ? tag_q : dqt_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q     <= '0;
			hi_q         <= '0;
			hint_q       <= '0;
			cnt_q        <= '0;
			scan_addr_q  <= '0;
			scan_lim_q   <= '0;
			rd_pend_q    <= 1'b0;
			scan_busy_q  <= 1'b0;
			hit_q        <= 1'b0;
			entry_q      <= '0;
			move_q       <= '0;
			move_dst_q   <= '0;
			srch_q       <= '0;
			srch_wrap_q  <= 1'b0;
			srch_busy_q  <= 1'b0;
			found_q      <= 1'b0;
			found_slot_q <= '0;
		end else begin
			// hazard scan over 2*hi words
			if (cmd.scan_init) begin
				scan_addr_q <= '0;
				scan_lim_q  <= {hi_q, 1'b0};
				hit_q       <= 1'b0;
				rd_pend_q   <= 1'b0;
				scan_busy_q <= 1'b1;
			end else if (scan_busy_q) begin
				if (rd_pend_q && hp_rdata == cand_q) hit_q <= 1'b1;
				if (scan_addr_q < scan_lim_q && !(rd_pend_q && hp_rdata == cand_q)) begin
					scan_addr_q <= scan_addr_q + 1'b1;
					rd_pend_q   <= 1'b1;
				end else begin
					rd_pend_q   <= 1'b0;
					scan_busy_q <= 1'b0;
				end
			end

			if (cmd.entry_ld) begin
				unique case (cmd.entry_src)
					2'd0:    entry_q <= CNT_W'(RETRIES);
					2'd1:    entry_q <= cnt_q - 1'b1;
					default: entry_q <= entry_q - 1'b1;
				endcase
			end

			// release: count drops, then last entry read, then written at dst
			if (cmd.rel_entry) begin
				cnt_q      <= cnt_q - 1'b1;
				move_dst_q <= entry_q[DIDX_W-1:0];
				move_q     <= 2'd2;
			end else if (move_q == 2'd2) begin
				move_q <= 2'd1;
			end else if (move_q == 2'd1) begin
				move_q <= 2'd0;
			end
			if (cmd.enqueue) cnt_q <= cnt_q + 1'b1;

			// attach search, one slot a cycle
			if (cmd.free_step && !srch_busy_q && !found_q) begin
				srch_busy_q <= 1'b1;
				srch_q      <= hint_q;
				srch_wrap_q <= 1'b0;
			end else if (srch_busy_q) begin
				if (srch_q >= srch_lim) begin
					if (srch_wrap_q) begin
						srch_busy_q <= 1'b0;
					end else begin
						srch_wrap_q <= 1'b1;
						srch_q      <= '0;
					end
				end else if (!in_use_q[srch_q[SLOT_W-1:0]]) begin
					found_q      <= 1'b1;
					found_slot_q <= srch_q[SLOT_W-1:0];
					srch_busy_q  <= 1'b0;
				end else begin
					srch_q <= srch_q + 1'b1;
				end
			end

			if (cmd.attach_do) begin
				in_use_q[found_slot_q] <= 1'b1;
				if ({1'b0, found_slot_q} + 1'b1 > hi_q) hi_q <= {1'b0, found_slot_q} + 1'b1;
				hint_q <= (hint_q + 1'b1 > (SLOT_W+1)'(SLOTS)) ? '0 : hint_q + 1'b1;
			end
			if (cmd.out_ld) found_q <= 1'b0;
			if (cmd.detach_do) in_use_q[slot_q] <= 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			result_kind      <= cmd.out_kind;
			released_pointer <= (cmd.out_src == 2'd1) ? cand_q : '0;
			released_tag     <= (cmd.out_src == 2'd1) ? cand_tag_q : '0;
			assigned_slot    <= (cmd.out_src == 2'd2) ? found_slot_q : '0;
			last_result      <= cmd.out_last;
		end
	end

	assign sts.action      = action_t'(act_q);
	assign sts.scan_busy   = scan_busy_q;
	assign sts.hazard      = hit_q;
	assign sts.search_busy = srch_busy_q;
	assign sts.found       = found_q;
	assign sts.detach_ok   = in_use_q[slot_q];
	assign sts.entry_valid = entry_q < cnt_q;
	assign sts.entry_zero  = entry_q == '0;
	assign sts.q_full      = cnt_q >= CNT_W'(DEPTH);
	assign sts.out_busy    = out_valid && out_stall;
	assign sts.move_busy   = move_q != 2'd0;
endmodule

FILE: rtl/hpr_ctrl.sv
// Controller state machine sequencing attach, detach, set, retire and flush.
// Depends on hpr_pkg.
`timescale 1ns / 1ps
module hpr_ctrl
	import hpr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  hpr_sts_t sts,
	output hpr_cmd_t cmd
);
	typedef enum logic [10:0] {
		S_IDLE   = 11'b00000000001,
		S_DEC    = 11'b00000000010,
		S_SRCH   = 11'b00000000100,
		S_CLR    = 11'b00000001000,
		S_ERD    = 11'b00000010000, // entry read issued
		S_ESCAN  = 11'b00000100000,
		S_EWAIT  = 11'b00001000000,
		S_NEXT   = 11'b00010000000,
		S_NSCAN  = 11'b00100000000,
		S_NEWDEC = 11'b01000000000,
		S_OUT    = 11'b10000000000
	} state_t;

	state_t state_q, state_d;
	logic   scan_go_q, scan_go_d;   // scan launched, wait for it to end
	logic   flush_q, flush_d;
	logic   ovalid_q;                // pending output held in cmd fields
	hpr_cmd_t pend_q, pend_d;
	logic   ovalid_d;

	assign in_stall = state_q != S_IDLE;

	always_comb begin
		state_d   = state_q;
		scan_go_d = scan_go_q;
		flush_d   = flush_q;
		cmd       = '0;
		cmd.out_kind = K_DONE;
		pend_d    = pend_q;
		ovalid_d  = ovalid_q;

		// staged result goes out once the output register is free
		if (ovalid_q && !sts.out_busy) begin
			cmd.out_ld   = 1'b1;
			cmd.out_kind = pend_q.out_kind;
			cmd.out_src  = pend_q.out_src;
			cmd.out_last = pend_q.out_last;
			ovalid_d     = 1'b0;
		end

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DEC;
				end
			end
			S_DEC: begin
				priority case (sts.action)
					ACT_ATTACH: begin
						cmd.free_step = 1'b1;
						state_d       = S_SRCH;
					end
					ACT_DETACH: begin
						cmd.detach_do = sts.detach_ok;
						pend_d.out_kind = sts.detach_ok ? K_DONE : K_BADDETACH;
						pend_d.out_src  = 2'd0; pend_d.out_last = 1'b1;
						ovalid_d = 1'b1; state_d = S_OUT;
					end
					ACT_SET: begin
						cmd.set_do = 1'b1;
						pend_d.out_kind = K_DONE; pend_d.out_src = 2'd0;
						pend_d.out_last = 1'b1; ovalid_d = 1'b1; state_d = S_OUT;
					end
					ACT_RETIRE: begin
						cmd.entry_ld = 1'b1; cmd.entry_src = 2'd0;
						flush_d = 1'b0; state_d = S_ERD;
					end
					ACT_FLUSH: begin
						cmd.entry_ld = 1'b1; cmd.entry_src = 2'd1;
						flush_d = 1'b1; state_d = S_ERD;
					end
					default: begin
						pend_d.out_kind = K_DONE; pend_d.out_src = 2'd0;
						pend_d.out_last = 1'b1; ovalid_d = 1'b1; state_d = S_OUT;
					end
				endcase
			end
			S_SRCH: begin
				// search was launched from decode; only wait for it here
				if (sts.found) begin
					cmd.attach_do = 1'b1; cmd.hp_clr = 1'b1; cmd.clr_sel = 1'b0;
					state_d = S_CLR;
				end
				if (!sts.found && !sts.search_busy && scan_go_q) begin
					pend_d.out_kind = K_NOSLOT; pend_d.out_src = 2'd0;
					pend_d.out_last = 1'b1; ovalid_d = 1'b1; state_d = S_OUT;
				end
				scan_go_d = sts.search_busy;
			end
			S_CLR: begin
				cmd.hp_clr = 1'b1; cmd.clr_sel = 1'b1;
				if (!ovalid_q) begin
					pend_d.out_kind = K_ASSIGNED; pend_d.out_src = 2'd2;
					pend_d.out_last = 1'b1; ovalid_d = 1'b1; state_d = S_OUT;
				end
			end
			S_ERD: begin
				// wait for any move to finish and the staged result to leave
				if (!sts.move_busy && !ovalid_q) begin
					if (sts.entry_valid)
						state_d = S_ESCAN;
					else
						state_d = S_NEXT;
				end
			end
			S_ESCAN: begin
				cmd.scan_init = 1'b1; cmd.cand_new = 1'b0;
				scan_go_d = 1'b0; state_d = S_EWAIT;
			end
			S_EWAIT: begin
				if (!sts.scan_busy && scan_go_q) begin
					if (!sts.hazard) begin
						cmd.rel_entry = 1'b1;
						pend_d.out_kind = K_RELEASE; pend_d.out_src = 2'd1;
						pend_d.out_last = 1'b0; ovalid_d = 1'b1;
					end
					state_d = S_NEXT;
				end
				scan_go_d = 1'b1;
			end
			S_NEXT: begin
				if (!sts.entry_zero) begin
					cmd.entry_ld = 1'b1; cmd.entry_src = 2'd2; state_d = S_ERD;
				end else if (flush_q) begin
					if (!ovalid_q) begin
						pend_d.out_kind = K_DONE; pend_d.out_src = 2'd0;
						pend_d.out_last = 1'b1; ovalid_d = 1'b1; state_d = S_OUT;
					end
				end else if (!ovalid_q && !sts.move_busy) begin
					cmd.scan_init = 1'b1; cmd.cand_new = 1'b1;
					scan_go_d = 1'b0; state_d = S_NSCAN;
				end
				if (sts.entry_zero && flush_q && ovalid_q) state_d = S_NEXT;
			end
			S_NSCAN: begin
				scan_go_d = 1'b1;
				if (!sts.scan_busy && scan_go_q) state_d = S_NEWDEC;
			end
			S_NEWDEC: begin
				if (!sts.hazard) begin
					pend_d.out_kind = K_RELEASE;
				end else if (!sts.q_full) begin
					cmd.enqueue = 1'b1; pend_d.out_kind = K_QUEUED;
				end else begin
					pend_d.out_kind = K_FULL;
				end
				pend_d.out_src = 2'd1; pend_d.out_last = 1'b1; ovalid_d = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!ovalid_q && !sts.out_busy) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			scan_go_q <= 1'b0;
			flush_q   <= 1'b0;
			ovalid_q  <= 1'b0;
			pend_q    <= '0;
		end else begin
			state_q   <= state_d;
			scan_go_q <= scan_go_d;
			flush_q   <= flush_d;
			ovalid_q  <= ovalid_d;
			pend_q    <= pend_d;
		end
	end
endmodule

FILE: rtl/hazard_pointer_reclaimer.sv
// Hazard pointer reclaimer. One transaction at a time; attach searches for a free
// slot one slot a cycle, each hazard scan reads two words a slot through one RAM
// port, and retire takes up to 4 scans. Results leave through an output register.
// Asynchronous active-low reset clears slot use, counts and hint; RAMs not cleared.
`timescale 1ns / 1ps
module hazard_pointer_reclaimer
	import hpr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        action,
	input  logic [SLOT_W-1:0] thread_slot,
	input  logic              hazard_index,
	input  logic [PTR_W-1:0]  pointer_value,
	input  logic [TAG_W-1:0]  release_tag,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        result_kind,
	output logic [PTR_W-1:0]  released_pointer,
	output logic [TAG_W-1:0]  released_tag,
	output logic [SLOT_W-1:0] assigned_slot,
	output logic              last_result
);
	hpr_cmd_t cmd;
	hpr_sts_t sts;

	hpr_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .sts, .cmd
	);
	hpr_datapath u_dp (
		.clk, .arst_n, .cmd, .sts, .action, .thread_slot, .hazard_index,
		.pointer_value, .release_tag, .out_valid, .out_stall, .result_kind,
		.released_pointer, .released_tag, .assigned_slot, .last_result
	);
endmodule

FILE: rtl/hpr_checker.sv
// Port-level checker for the hazard pointer reclaimer, bound to the top level.
// Depends on hpr_pkg.
`timescale 1ns / 1ps
module hpr_checker
	import hpr_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] result_kind,
	input logic       last_result
);
	// no new transaction accepted while a result is held on the output
	a_no_accept_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input accepted while output stalled");
	// kinds 3 to 6 are always final
	a_final_kinds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind == K_ASSIGNED || result_kind == K_NOSLOT ||
		result_kind == K_DONE || result_kind == K_BADDETACH) |-> last_result)
		else $error("terminal kind without last flag");
	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_kind))
		else $error("stalled result changed");
endmodule

bind hazard_pointer_reclaimer hpr_checker u_hpr_checker (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
	.result_kind, .last_result
);

FILE: verif/testbench.sv
// Testbench for hazard_pointer_reclaimer: directed and random transactions,
// with results checked against a behavioural predictor of the slot table and delay queue.
// Depends on rtl/hpr_pkg.sv and rtl/hazard_pointer_reclaimer.sv.
`timescale 1ns / 1ps
module testbench;
	import hpr_pkg::*;

	typedef struct {
		kind_t             kind;
		logic [PTR_W-1:0]  ptr;
		logic [TAG_W-1:0]  tag;
		logic [SLOT_W-1:0] slot;
		logic              last;
	} reclaim_result_t;

	class reclaim_scoreboard;
		bit               in_use[SLOTS];
		logic [PTR_W-1:0] hazard[2*SLOTS];
		bit               hazard_known[2*SLOTS];
		int unsigned      top;
		int unsigned      hint;
		logic [PTR_W-1:0] delayed_ptr[DEPTH];
		logic [TAG_W-1:0] delayed_tag[DEPTH];
		int unsigned      delayed_cnt;
		reclaim_result_t  due[$];
		int               errors;

		function void push(kind_t k, logic [PTR_W-1:0] p, logic [TAG_W-1:0] t,
				logic [SLOT_W-1:0] s, logic l);
			reclaim_result_t r;
			r.kind = k; r.ptr = p; r.tag = t; r.slot = s; r.last = l;
			due.push_back(r);
		endfunction

		function bit guarded(logic [PTR_W-1:0] p);
			for (int i = 0; i < top && i < SLOTS; i++)
				if (hazard[2*i] == p || hazard[2*i+1] == p)
					return 1;
			return 0;
		endfunction

		// true when a scan would read a hazard word that was never written
		function bit scan_unsafe(output int unsigned word);
			for (int i = 0; i < 2*top && i < 2*SLOTS; i++)
				if (!hazard_known[i]) begin
					word = i;
					return 1;
				end
			word = 0;
			return 0;
		endfunction

		function void retry_entry(int unsigned idx);
			logic [PTR_W-1:0] p;
			logic [TAG_W-1:0] t;
			if (idx >= delayed_cnt)
				return;
			p = delayed_ptr[idx];
			t = delayed_tag[idx];
			if (guarded(p))
				return;
			delayed_cnt--;
			delayed_ptr[idx] = delayed_ptr[delayed_cnt];
			delayed_tag[idx] = delayed_tag[delayed_cnt];
			push(K_RELEASE, p, t, '0, 1'b0);
		endfunction

		function void note_input(logic [2:0] act, logic [SLOT_W-1:0] slot, logic hidx,
				logic [PTR_W-1:0] ptr, logic [TAG_W-1:0] tag);
			int found;
			found = -1;
			case (act)
				ACT_ATTACH: begin
					for (int s = hint; s < SLOTS; s++)
						if (!in_use[s]) begin
							found = s;
							break;
						end
					if (found < 0)
						for (int s = 0; s < hint && s < SLOTS; s++)
							if (!in_use[s]) begin
								found = s;
								break;
							end
					if (found < 0) begin
						push(K_NOSLOT, '0, '0, '0, 1'b1);
					end else begin
						in_use[found] = 1;
						hazard[2*found] = '0;
						hazard[2*found+1] = '0;
						hazard_known[2*found] = 1;
						hazard_known[2*found+1] = 1;
						if (found + 1 > top)
							top = found + 1;
						hint++;
						if (hint > SLOTS)
							hint = 0;
						push(K_ASSIGNED, '0, '0, SLOT_W'(found), 1'b1);
					end
				end
				ACT_DETACH: begin
					if (!in_use[slot]) begin
						push(K_BADDETACH, '0, '0, '0, 1'b1);
					end else begin
						in_use[slot] = 0;
						push(K_DONE, '0, '0, '0, 1'b1);
					end
				end
				ACT_SET: begin
					hazard[2*slot+hidx] = ptr;
					hazard_known[2*slot+hidx] = 1;
					push(K_DONE, '0, '0, '0, 1'b1);
				end
				ACT_RETIRE: begin
					for (int i = RETRIES; i >= 0; i--)
						retry_entry(i);
					if (!guarded(ptr)) begin
						push(K_RELEASE, ptr, tag, '0, 1'b1);
					end else if (delayed_cnt < DEPTH) begin
						delayed_ptr[delayed_cnt] = ptr;
						delayed_tag[delayed_cnt] = tag;
						delayed_cnt++;
						push(K_QUEUED, ptr, tag, '0, 1'b1);
					end else begin
						push(K_FULL, ptr, tag, '0, 1'b1);
					end
				end
				ACT_FLUSH: begin
					for (int k = delayed_cnt; k > 0; k--)
						retry_entry(k - 1);
					push(K_DONE, '0, '0, '0, 1'b1);
				end
				default: begin
					push(K_DONE, '0, '0, '0, 1'b1);
				end
			endcase
		endfunction

		function void check_result(logic [2:0] kind, logic [PTR_W-1:0] ptr,
				logic [TAG_W-1:0] tag, logic [SLOT_W-1:0] slot, logic last);
			reclaim_result_t e;
			if (due.size() == 0) begin
				$display("%0t: unexpected result kind %0d ptr %h", $time, kind, ptr);
				errors++;
				return;
			end
			e = due.pop_front();
			if (kind !== e.kind) begin
				$display("%0t: result_kind expected %0d actual %0d", $time, e.kind, kind);
				errors++;
			end
			if (ptr !== e.ptr) begin
				$display("%0t: released_pointer expected %h actual %h", $time, e.ptr, ptr);
				errors++;
			end
			if (tag !== e.tag) begin
				$display("%0t: released_tag expected %h actual %h", $time, e.tag, tag);
				errors++;
			end
			if (slot !== e.slot) begin
				$display("%0t: assigned_slot expected %0d actual %0d", $time, e.slot, slot);
				errors++;
			end
			if (last !== e.last) begin
				$display("%0t: last_result expected %0d actual %0d", $time, e.last, last);
				errors++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [2:0]        action = '0;
	logic [SLOT_W-1:0] thread_slot = '0;
	logic              hazard_index = 1'b0;
	logic [PTR_W-1:0]  pointer_value = '0;
	logic [TAG_W-1:0]  release_tag = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [2:0]        result_kind;
	logic [PTR_W-1:0]  released_pointer;
	logic [TAG_W-1:0]  released_tag;
	logic [SLOT_W-1:0] assigned_slot;
	logic              last_result;

	reclaim_scoreboard sb = new();
	int                send_idle_pct = 0;
	int                recv_stall_pct = 0;
	bit                hold_req = 0;
	int unsigned       cycle_cnt = 0;
	logic [PTR_W-1:0]  ptr_pool[8];

	hazard_pointer_reclaimer u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .thread_slot(thread_slot), .hazard_index(hazard_index),
		.pointer_value(pointer_value), .release_tag(release_tag),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_kind(result_kind), .released_pointer(released_pointer),
		.released_tag(released_tag), .assigned_slot(assigned_slot),
		.last_result(last_result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > 3000000) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// result side: check, then choose the stall for the next cycle
	int hold_left = 0;
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(result_kind, released_pointer, released_tag, assigned_slot,
				last_result);
		if (hold_req && hold_left == 0) begin
			hold_req = 0;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic offer(input logic [2:0] a, input logic [SLOT_W-1:0] s, input logic h,
			input logic [PTR_W-1:0] p, input logic [TAG_W-1:0] t);
		in_valid <= 1'b1;
		action <= a;
		thread_slot <= s;
		hazard_index <= h;
		pointer_value <= p;
		release_tag <= t;
		do @(posedge clk); while (in_stall);
		sb.note_input(a, s, h, p, t);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.due.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	function automatic logic [PTR_W-1:0] pick_ptr();
		if ($urandom_range(99) < 70)
			return ptr_pool[$urandom_range(7)];
		return {$urandom, $urandom};
	endfunction

	function automatic logic [SLOT_W-1:0] pick_slot();
		if (sb.top > 0 && $urandom_range(99) < 75)
			return SLOT_W'($urandom_range(sb.top - 1));
		return SLOT_W'($urandom_range(SLOTS - 1));
	endfunction

	task automatic random_items(input int count, input int attach_burst);
		logic [2:0]  a;
		int          w;
		int unsigned word;
		for (int n = 0; n < count; n++) begin
			w = $urandom_range(99);
			if (n < attach_burst)      a = ACT_ATTACH;
			else if (w < 18)           a = ACT_ATTACH;
			else if (w < 32)           a = ACT_DETACH;
			else if (w < 55)           a = ACT_SET;
			else if (w < 88)           a = ACT_RETIRE;
			else if (w < 96)           a = ACT_FLUSH;
			else                       a = 3'($urandom_range(5, 7));
			if ((a == ACT_RETIRE || a == ACT_FLUSH) && sb.scan_unsafe(word))
				offer(ACT_SET, SLOT_W'(word / 2), word[0], pick_ptr(), 8'($urandom));
			else
				offer(a, pick_slot(), 1'($urandom), pick_ptr(), 8'($urandom));
		end
	endtask

	initial begin
		ptr_pool[0] = '0;
		ptr_pool[1] = '1;
		for (int i = 2; i < 8; i++)
			ptr_pool[i] = {$urandom, $urandom};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: table edges, null and all-ones pointers, bad detach, unknown codes
		offer(ACT_ATTACH, '0, 1'b0, '0, '0);
		offer(ACT_ATTACH, '0, 1'b0, '0, '0);
		offer(ACT_ATTACH, '0, 1'b0, '0, '0);
		offer(ACT_SET, 6'd0, 1'b0, '1, '0);
		offer(ACT_SET, 6'd0, 1'b1, 64'h0, '0);
		offer(ACT_SET, 6'd1, 1'b0, 64'h5555_5555_5555_5555, '0);
		offer(ACT_SET, 6'd1, 1'b1, 64'haaaa_aaaa_aaaa_aaaa, '0);
		offer(ACT_SET, 6'd63, 1'b1, 64'h1234, '0);
		offer(ACT_RETIRE, '0, 1'b0, '1, 8'hff);
		offer(ACT_RETIRE, '0, 1'b0, '0, 8'h00);
		offer(ACT_RETIRE, '0, 1'b0, 64'h1234, 8'h5a);
		offer(ACT_RETIRE, '0, 1'b0, 64'haaaa_aaaa_aaaa_aaaa, 8'ha5);
		offer(ACT_DETACH, 6'd2, 1'b0, '0, '0);
		offer(ACT_DETACH, 6'd2, 1'b0, '0, '0);
		offer(ACT_DETACH, 6'd63, 1'b0, '0, '0);
		offer(3'd5, '0, 1'b0, '0, '0);
		offer(3'd6, '0, 1'b0, '0, '0);
		offer(3'd7, '0, 1'b0, '0, '0);
		offer(ACT_FLUSH, '0, 1'b0, '0, '0);
		offer(ACT_SET, 6'd0, 1'b0, 64'h77, '0);
		offer(ACT_SET, 6'd1, 1'b1, 64'h77, '0);
		offer(ACT_RETIRE, '0, 1'b0, 64'h99, 8'h01);
		offer(ACT_SET, 6'd0, 1'b1, 64'h78, '0);
		offer(ACT_FLUSH, '0, 1'b0, '0, '0);
		drain();

		send_idle_pct = 28;
		recv_stall_pct = 66;
		hold_req = 1;
		random_items(120, 0);
		drain();

		send_idle_pct = 66;
		recv_stall_pct = 28;
		random_items(120, 70);
		drain();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		random_items(120, 0);
		drain();

		if (sb.errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end
endmodule

FILE: sim.f
rtl/hpr_pkg.sv
rtl/hpr_ram.sv
rtl/hpr_datapath.sv
rtl/hpr_ctrl.sv
rtl/hazard_pointer_reclaimer.sv
rtl/hpr_checker.sv
verif/testbench.sv
